>>> sv/dlcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dlcs_pkg
// Types and constants for the display-list command sequencer: the command
// and result transfer structs, opcodes, move-word indexes and status codes.
// ----------------------------------------------------------------------------
package dlcs_pkg;

    // Address and segment table geometry.
    localparam int ADDR_W        = 24;
    localparam int SEGMENT_COUNT = 16;
    localparam int SEG_W         = $clog2(SEGMENT_COUNT);

    // Opcodes.
    localparam logic [7:0] OP_DISPLAY_LIST = 8'h06;
    localparam logic [7:0] OP_CLEAR_GEO    = 8'hB6;
    localparam logic [7:0] OP_SET_GEO      = 8'hB7;
    localparam logic [7:0] OP_END_LIST     = 8'hB8;
    localparam logic [7:0] OP_MODE_LOW     = 8'hB9;
    localparam logic [7:0] OP_MODE_HIGH    = 8'hBA;
    localparam logic [7:0] OP_MOVE_WORD    = 8'hBC;

    // Move-word indexes.
    localparam logic [7:0] MW_LIGHTS  = 8'h02;
    localparam logic [7:0] MW_SEGMENT = 8'h06;

    // Call flag value in bits 23..16 of the first word.
    localparam logic [7:0] DL_CALL = 8'h00;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_HANDLED  = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_LIST_END = 2'd3
    } t_status;

    // One display-list command.
    typedef struct packed {
        logic [7:0]  command;
        logic [23:0] first_params;
        logic [31:0] second_word;
    } t_cmd;

    // One result.
    typedef struct packed {
        logic [23:0] next_address;
        logic        halted;
        logic [2:0]  call_depth;
        logic [31:0] geometry_bits;
        logic [31:0] render_low_bits;
        logic [31:0] render_high_bits;
        logic [31:0] change_mask;
        logic [2:0]  light_count;
        t_status     status;
    } t_result;

endpackage
`default_nettype wire

>>> sv/display_list_command_sequencer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// display_list_command_sequencer_top
// Decodes one display-list command per transfer and returns the next fetch
// address together with the stack, halt, mode-word and light-count state.
// ----------------------------------------------------------------------------
// The input transfer loads the input register; when the decode stage fires,
//   the result register is loaded and the result is offered from it.
// Throughput: one command per cycle while the result register is free or
//   being emptied; the single decode stage between the input and result
//   registers updates all state in the cycle it fires.
// Reset clears the address, stack pointer, halt flag, mode words, light
//   count and all segment bases at once; there is no clearing pass.
module display_list_command_sequencer_top #(
    parameter int STACK_DEPTH = 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    input  wire dlcs_pkg::t_cmd i_in_data,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output dlcs_pkg::t_result o_out_data
);
    import dlcs_pkg::*;

    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [SP_W-1:0] SP_MAX = SP_W'(STACK_DEPTH - 1);

    // Pipeline registers.
    logic    r_in_vld;
    t_cmd    r_in;
    logic    r_out_vld;
    t_result r_out;

    // Sequencer state. The current address is the top of the stack; the
    // array holds the saved return addresses below it.
    logic [ADDR_W-1:0] r_cur_addr;
    logic [ADDR_W-1:0] r_stack [STACK_DEPTH];
    logic [SP_W-1:0]   r_sp;
    logic              r_halt;
    logic [ADDR_W-1:0] r_seg_base [SEGMENT_COUNT];
    logic [31:0]       r_geo;
    logic [31:0]       r_mode_lo;
    logic [31:0]       r_mode_hi;
    logic [2:0]        r_lights;

    // Next-state values.
    logic [ADDR_W-1:0] n_cur_addr;
    logic [SP_W-1:0]   n_sp;
    logic              n_halt;
    logic [31:0]       n_geo;
    logic [31:0]       n_mode_lo;
    logic [31:0]       n_mode_hi;
    logic [2:0]        n_lights;
    logic [31:0]       n_change;
    t_status           n_status;
    logic              n_push;
    logic              n_seg_wr;
    t_result           n_out;

    // Decode helpers.
    logic              fire;
    logic [7:0]        op;
    logic [23:0]       prm;
    logic [31:0]       wrd;
    logic [ADDR_W-1:0] adv_addr;
    logic [ADDR_W-1:0] target_addr;
    logic [SP_W-1:0]   sp_dec;
    logic [7:0]        fld_shift;
    logic [7:0]        fld_len;
    logic [31:0]       fld_ones;
    logic [31:0]       fld_mask;
    logic [31:0]       mode_old;
    logic [31:0]       mode_new;
    logic [SP_W+2:0]   sp_ext;

    // Handshake: the decode stage fires when the result register is free or
    // being emptied, and the input register refills in the same cycle.
    assign fire        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || fire;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    assign op  = r_in.command;
    assign prm = r_in.first_params;
    assign wrd = r_in.second_word;

    // Address arithmetic: sequential advance, segment translation and pop.
    assign adv_addr    = r_cur_addr + ADDR_W'(8);
    assign target_addr = r_seg_base[wrd[24 +: SEG_W]] + wrd[ADDR_W-1:0];
    assign sp_dec      = r_sp - SP_W'(1);

    // Masked field for the other-mode writes.
    assign fld_shift = prm[15:8];
    assign fld_len   = prm[7:0];
    assign fld_ones  = (fld_len >= 8'd32) ? 32'hFFFF_FFFF
                                          : ((32'd1 << fld_len[4:0]) - 32'd1);
    assign fld_mask  = (fld_shift >= 8'd32) ? 32'd0 : (fld_ones << fld_shift[4:0]);
    assign mode_old  = (op == OP_MODE_LOW) ? r_mode_lo : r_mode_hi;
    assign mode_new  = (mode_old & ~fld_mask) | (wrd & fld_mask);

    // Command decode and next-state selection.
    always_comb begin
        n_cur_addr = r_cur_addr;
        n_sp       = r_sp;
        n_halt     = r_halt;
        n_geo      = r_geo;
        n_mode_lo  = r_mode_lo;
        n_mode_hi  = r_mode_hi;
        n_lights   = r_lights;
        n_change   = 32'd0;
        n_status   = ST_HANDLED;
        n_push     = 1'b0;
        n_seg_wr   = 1'b0;
        if (r_halt) begin
            n_status = ST_IGNORED;
        end else begin
            case (op)
                OP_DISPLAY_LIST: begin
                    if (prm[23:16] == DL_CALL) begin
                        if (r_sp != SP_MAX) begin
                            n_push     = 1'b1;
                            n_sp       = r_sp + SP_W'(1);
                            n_cur_addr = target_addr;
                        end else begin
                            n_halt   = 1'b1;
                            n_status = ST_OVERFLOW;
                        end
                    end else begin
                        n_cur_addr = target_addr;
                    end
                end
                OP_CLEAR_GEO: begin
                    n_geo      = r_geo & ~wrd;
                    n_change   = r_geo & wrd;
                    n_cur_addr = adv_addr;
                end
                OP_SET_GEO: begin
                    n_geo      = r_geo | wrd;
                    n_change   = ~r_geo & wrd;
                    n_cur_addr = adv_addr;
                end
                OP_END_LIST: begin
                    if (r_sp != '0) begin
                        n_sp       = sp_dec;
                        n_cur_addr = r_stack[sp_dec];
                    end else begin
                        n_halt   = 1'b1;
                        n_status = ST_LIST_END;
                    end
                end
                OP_MODE_LOW: begin
                    n_mode_lo  = mode_new;
                    n_change   = mode_old ^ mode_new;
                    n_cur_addr = adv_addr;
                end
                OP_MODE_HIGH: begin
                    n_mode_hi  = mode_new;
                    n_change   = mode_old ^ mode_new;
                    n_cur_addr = adv_addr;
                end
                OP_MOVE_WORD: begin
                    if (prm[7:0] == MW_SEGMENT) begin
                        n_seg_wr = 1'b1;
                    end else if (prm[7:0] == MW_LIGHTS) begin
                        n_lights = wrd[7:5] - 3'd1;
                    end else begin
                        n_status = ST_IGNORED;
                    end
                    n_cur_addr = adv_addr;
                end
                default: begin
                    n_status   = ST_IGNORED;
                    n_cur_addr = adv_addr;
                end
            endcase
        end
    end

    // Result assembly from the updated state.
    assign sp_ext = {3'b000, n_sp};

    always_comb begin
        n_out.next_address     = n_cur_addr;
        n_out.halted           = n_halt;
        n_out.call_depth       = sp_ext[2:0];
        n_out.geometry_bits    = n_geo;
        n_out.render_low_bits  = n_mode_lo;
        n_out.render_high_bits = n_mode_hi;
        n_out.change_mask      = n_change;
        n_out.light_count      = n_lights;
        n_out.status           = n_status;
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_cur_addr <= '0;
            r_sp       <= '0;
            r_halt     <= 1'b0;
            r_geo      <= '0;
            r_mode_lo  <= '0;
            r_mode_hi  <= '0;
            r_lights   <= '0;
            for (int i = 0; i < SEGMENT_COUNT; i++) begin
                r_seg_base[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (fire) begin
                r_out_vld  <= 1'b1;
                r_cur_addr <= n_cur_addr;
                r_sp       <= n_sp;
                r_halt     <= n_halt;
                r_geo      <= n_geo;
                r_mode_lo  <= n_mode_lo;
                r_mode_hi  <= n_mode_hi;
                r_lights   <= n_lights;
                if (n_seg_wr) begin
                    r_seg_base[prm[10 +: SEG_W]] <= wrd[ADDR_W-1:0];
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload registers and the return stack need no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
        if (fire && n_push) begin
            r_stack[r_sp] <= adv_addr;
        end
    end

    // The stack pointer never passes the deepest level.
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_MAX)
        else $error("stack pointer beyond the deepest level");

    // Once halted, the sequencer stays halted until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    // A halted sequencer leaves the mode words and address untouched.
    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_halt) |=> ($stable(r_geo) && $stable(r_mode_lo)
                              && $stable(r_mode_hi) && $stable(r_cur_addr)))
        else $error("state changed while halted");

    // A halting result reports halted and changes no mode bits.
    a_halt_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && (r_out.status == ST_OVERFLOW || r_out.status == ST_LIST_END))
        |-> (r_out.halted && r_out.change_mask == 32'd0))
        else $error("halting result inconsistent");

    // Every transfer into the decode stage produces a result next cycle.
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("result lost after decode");

endmodule
`default_nettype wire

>>> sim/display_list_command_sequencer_top_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// display_list_command_sequencer_top_test
// Self-checking bench for the display-list command sequencer. A queue of
// commands feeds a valid/ready driver; a monitor predicts each result on the
// input transfer and compares it, field by field, with the block's output.
// Directed commands cover the mode-field edge cases, segment and light writes,
// address wrap and a full call stack. Random well-formed call/return traffic
// follows, and the run closes with a halt (stack overflow or list end, picked
// at random) followed by commands that must all be ignored.
// ----------------------------------------------------------------------------
module display_list_command_sequencer_top_test;
    import dlcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH = 8;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_PER_PHASE = 400;
    localparam int REPORT_LIMIT = 10;

    // Opcodes and move-word indexes that the block does not decode.
    localparam logic [7:0] OP_UNUSED_LOW  = 8'h00;
    localparam logic [7:0] OP_UNUSED_HIGH = 8'hFF;
    localparam logic [7:0] MW_UNUSED      = 8'hFF;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_ready;
    t_cmd    in_data = '0;
    logic    out_valid;
    logic    out_ready = 1'b0;
    t_result out_data;

    // Stimulus bookkeeping.
    t_cmd    command_queue[$];
    t_result awaited_results[$];
    int      queued_cmds = 0;
    int      accepted_cmds = 0;
    int      plan_depth = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      error_count = 0;
    int      cycle_count = 0;

    // Predicted sequencer state.
    logic [23:0] ret_addr [STACK_DEPTH] = '{default: '0};
    logic [23:0] seg_base [SEGMENT_COUNT] = '{default: '0};
    int          ret_depth = 0;
    logic        seq_halted = 1'b0;
    logic [31:0] geo_word = '0;
    logic [31:0] mode_lo = '0;
    logic [31:0] mode_hi = '0;
    logic [2:0]  lights = '0;

    display_list_command_sequencer_top #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // Clock generation.
    initial begin
        forever #2 clk = ~clk;
    end

    // Segmented address: base of the segment in bits 27..24 plus the offset.
    function automatic logic [23:0] segment_address(logic [31:0] w);
        return seg_base[w[27:24]] + w[23:0];
    endfunction

    // Mask for a shift/length mode-field write.
    function automatic logic [31:0] field_mask(logic [23:0] p);
        logic [31:0] ones;
        if (p[15:8] >= 8'd32) begin
            return '0;
        end
        ones = (p[7:0] >= 8'd32) ? 32'hFFFF_FFFF : ((32'd1 << p[7:0]) - 32'd1);
        return ones << p[15:8];
    endfunction

    function automatic void advance_address();
        ret_addr[ret_depth] = ret_addr[ret_depth] + 24'd8;
    endfunction

    // Applies one command to the predicted state and returns its result.
    function automatic t_result sequence_command(t_cmd c);
        t_result     r;
        logic [31:0] old_word;
        logic [31:0] mask;
        r = '0;
        r.status = ST_HANDLED;
        if (seq_halted) begin
            r.status = ST_IGNORED;
        end else begin
            case (c.command)
                OP_DISPLAY_LIST: begin
                    if (c.first_params[23:16] == DL_CALL) begin
                        if (ret_depth < STACK_DEPTH - 1) begin
                            advance_address();
                            ret_depth++;
                            ret_addr[ret_depth] = segment_address(c.second_word);
                        end else begin
                            seq_halted = 1'b1;
                            r.status = ST_OVERFLOW;
                        end
                    end else begin
                        ret_addr[ret_depth] = segment_address(c.second_word);
                    end
                end
                OP_CLEAR_GEO: begin
                    old_word = geo_word;
                    geo_word = geo_word & ~c.second_word;
                    r.change_mask = old_word ^ geo_word;
                    advance_address();
                end
                OP_SET_GEO: begin
                    old_word = geo_word;
                    geo_word = geo_word | c.second_word;
                    r.change_mask = old_word ^ geo_word;
                    advance_address();
                end
                OP_END_LIST: begin
                    if (ret_depth > 0) begin
                        ret_depth--;
                    end else begin
                        seq_halted = 1'b1;
                        r.status = ST_LIST_END;
                    end
                end
                OP_MODE_LOW: begin
                    mask = field_mask(c.first_params);
                    r.change_mask = (mode_lo ^ c.second_word) & mask;
                    mode_lo = mode_lo ^ r.change_mask;
                    advance_address();
                end
                OP_MODE_HIGH: begin
                    mask = field_mask(c.first_params);
                    r.change_mask = (mode_hi ^ c.second_word) & mask;
                    mode_hi = mode_hi ^ r.change_mask;
                    advance_address();
                end
                OP_MOVE_WORD: begin
                    if (c.first_params[7:0] == MW_SEGMENT) begin
                        seg_base[c.first_params[13:10]] = c.second_word[23:0];
                    end else if (c.first_params[7:0] == MW_LIGHTS) begin
                        lights = c.second_word[7:5] - 3'd1;
                    end else begin
                        r.status = ST_IGNORED;
                    end
                    advance_address();
                end
                default: begin
                    r.status = ST_IGNORED;
                    advance_address();
                end
            endcase
        end
        r.next_address = ret_addr[ret_depth];
        r.halted = seq_halted;
        r.call_depth = 3'(ret_depth);
        r.geometry_bits = geo_word;
        r.render_low_bits = mode_lo;
        r.render_high_bits = mode_hi;
        r.light_count = lights;
        return r;
    endfunction

    // Queues one command and tracks the stack depth the sequence will reach.
    function automatic void queue_command(logic [7:0] op, logic [23:0] p, logic [31:0] w);
        t_cmd c;
        c.command = op;
        c.first_params = p;
        c.second_word = w;
        command_queue.push_back(c);
        queued_cmds++;
        if (op == OP_DISPLAY_LIST && p[23:16] == DL_CALL && plan_depth < STACK_DEPTH - 1) begin
            plan_depth++;
        end else if (op == OP_END_LIST && plan_depth > 0) begin
            plan_depth--;
        end
    endfunction

    // One random command. Calls and list ends are steered so that the list
    // neither overflows nor ends before the closing halt.
    function automatic void queue_random_command();
        int unsigned pick;
        logic [7:0]  op;
        logic [23:0] p;
        logic [31:0] w;
        pick = $urandom_range(99, 0);
        p = 24'($urandom);
        w = $urandom;
        op = OP_UNUSED_LOW;
        if (pick < 16 && plan_depth == STACK_DEPTH - 1) begin
            pick = 24;
        end else if (pick >= 24 && pick < 38 && plan_depth == 0) begin
            pick = 0;
        end
        if (pick < 16) begin
            op = OP_DISPLAY_LIST;
            p[23:16] = DL_CALL;
        end else if (pick < 24) begin
            op = OP_DISPLAY_LIST;
            if (p[23:16] == DL_CALL) begin
                p[23:16] = 8'($urandom_range(255, 1));
            end
        end else if (pick < 38) begin
            op = OP_END_LIST;
        end else if (pick < 54) begin
            op = (pick < 46) ? OP_CLEAR_GEO : OP_SET_GEO;
            if ($urandom_range(1, 0) == 0) begin
                w = w & $urandom;
            end
        end else if (pick < 78) begin
            op = (pick < 66) ? OP_MODE_LOW : OP_MODE_HIGH;
            if ($urandom_range(4, 0) != 0) begin
                p[15:8] = 8'($urandom_range(35, 0));
                p[7:0] = 8'($urandom_range(40, 0));
            end
        end else if (pick < 92) begin
            op = OP_MOVE_WORD;
            pick = $urandom_range(9, 0);
            if (pick < 5) begin
                p[7:0] = MW_SEGMENT;
            end else if (pick < 8) begin
                p[7:0] = MW_LIGHTS;
            end
        end else begin
            op = 8'($urandom);
            while (op == OP_DISPLAY_LIST || op == OP_END_LIST) begin
                op = 8'($urandom);
            end
        end
        queue_command(op, p, w);
    endfunction

    // Drives the list into a halt, then sends commands that must be ignored.
    function automatic void queue_halt_tail();
        if ($urandom_range(1, 0) == 1) begin
            while (plan_depth < STACK_DEPTH - 1) begin
                queue_command(OP_DISPLAY_LIST, {DL_CALL, 16'($urandom)}, $urandom);
            end
            queue_command(OP_DISPLAY_LIST, {DL_CALL, 16'($urandom)}, $urandom);
        end else begin
            while (plan_depth > 0) begin
                queue_command(OP_END_LIST, 24'($urandom), $urandom);
            end
            queue_command(OP_END_LIST, 24'($urandom), $urandom);
        end
        repeat (12) queue_random_command();
    endfunction

    // Edge cases first: mode fields, segment and light writes, wrap, full stack.
    function automatic void queue_directed_commands();
        queue_command(OP_SET_GEO, 24'h00_0000, 32'hFFFF_FFFF);
        queue_command(OP_CLEAR_GEO, 24'hFF_FFFF, 32'h0F0F_0F0F);
        // Length of 32 saturates; a shift of 32 leaves nothing to write.
        queue_command(OP_MODE_LOW, 24'h00_0020, 32'hA5A5_A5A5);
        queue_command(OP_MODE_LOW, 24'h00_2008, 32'hFFFF_FFFF);
        queue_command(OP_MODE_HIGH, 24'h00_04FF, 32'hFFFF_FFFF);
        queue_command(OP_MODE_HIGH, 24'h00_1F01, 32'h0000_0000);
        queue_command(OP_MODE_HIGH, 24'hFF_0000, 32'h1234_5678);
        // Segment 15 at the top of the address space, segment 1 mid-range.
        queue_command(OP_MOVE_WORD, {16'h003C, MW_SEGMENT}, 32'hFFFF_FFFF);
        queue_command(OP_MOVE_WORD, {16'h0004, MW_SEGMENT}, 32'h0012_3456);
        queue_command(OP_MOVE_WORD, {16'h0000, MW_LIGHTS}, 32'h0000_0000);
        queue_command(OP_MOVE_WORD, {16'hFFFF, MW_LIGHTS}, 32'hFFFF_FFFF);
        queue_command(OP_MOVE_WORD, {16'h0000, MW_UNUSED}, 32'h0000_0000);
        queue_command(OP_UNUSED_LOW, 24'h00_0000, 32'h0000_0000);
        queue_command(OP_UNUSED_HIGH, 24'hFF_FFFF, 32'hFFFF_FFFF);
        queue_command(OP_DISPLAY_LIST, 24'hFF_FFFF, 32'h0100_0010);
        // The first call lands near the top so that the return address wraps.
        queue_command(OP_DISPLAY_LIST, {DL_CALL, 16'h0000}, 32'hFFFF_FFFF);
        while (plan_depth < STACK_DEPTH - 1) begin
            queue_command(OP_DISPLAY_LIST, {DL_CALL, 16'($urandom)}, $urandom);
        end
        while (plan_depth > 0) begin
            queue_command(OP_END_LIST, 24'($urandom), $urandom);
        end
    endfunction

    // Waits until every queued command has been accepted and answered.
    task automatic wait_for_drain();
        while (accepted_cmds < queued_cmds || awaited_results.size() != 0) begin
            @(posedge clk);
        end
    endtask

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
                $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
            end
        end
    endtask

    // Command driver: offers the next queued command once the current one
    // has been transferred, with random idle cycles.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (command_queue.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                in_data <= command_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure.
    always @(posedge clk) begin
        out_ready <= rst_n && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // Monitor: predicts on each command transfer, checks each result transfer.
    always @(posedge clk) begin : monitor
        t_result want;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                awaited_results.push_back(sequence_command(in_data));
                accepted_cmds++;
            end
            if (out_valid && out_ready) begin
                if (awaited_results.size() == 0) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: unexpected result %h", $realtime, out_data);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    check_field("next_address", 32'(want.next_address),
                                32'(out_data.next_address));
                    check_field("halted", 32'(want.halted), 32'(out_data.halted));
                    check_field("call_depth", 32'(want.call_depth),
                                32'(out_data.call_depth));
                    check_field("geometry_bits", want.geometry_bits, out_data.geometry_bits);
                    check_field("render_low_bits", want.render_low_bits,
                                out_data.render_low_bits);
                    check_field("render_high_bits", want.render_high_bits,
                                out_data.render_high_bits);
                    check_field("change_mask", want.change_mask, out_data.change_mask);
                    check_field("light_count", 32'(want.light_count),
                                32'(out_data.light_count));
                    check_field("status", 32'(want.status), 32'(out_data.status));
                end
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Test sequence: reset, then three idling phases.
    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Sender mostly busy, receiver often stalling.
        send_idle_pct = 15;
        recv_idle_pct = 68;
        queue_directed_commands();
        repeat (RANDOM_PER_PHASE) queue_random_command();
        wait_for_drain();

        // Sender often idle, receiver mostly ready.
        send_idle_pct = 68;
        recv_idle_pct = 15;
        repeat (RANDOM_PER_PHASE) queue_random_command();
        wait_for_drain();

        // Full rate both ways, ending in a halt.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) queue_random_command();
        queue_halt_tail();
        wait_for_drain();

        // Allow for the pipeline latency so that stray results are caught.
        repeat (8) @(posedge clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
`default_nettype wire
